// File: rtl/core/flash_program_erase_sequencer_macros.svh
// Assertion macros for the flash program/erase sequencer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FLASH_PROGRAM_ERASE_SEQUENCER_MACROS_SVH
`define FLASH_PROGRAM_ERASE_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
// cond must hold at every edge out of reset
`define FPES_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fpes assertion failed");
// pre at an edge implies post at the same edge
`define FPES_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fpes assertion failed");
`else
`define FPES_ASSERT_ALWAYS(lbl, cond)
`define FPES_ASSERT_IMPLY(lbl, pre, post)
`endif

`endif

// File: rtl/core/fpes_pkg.sv
// Shared types and constants of the flash program/erase sequencer.
// No dependencies.
`timescale 1ns / 1ps

package fpes_pkg;

    localparam int MAX_UNIT_DEF    = 256;
    localparam int RETRY_LIMIT_DEF = 20;
    localparam int FIFO_DEPTH_DEF  = 4;

    // phases
    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_ERASE        = 3'd1;
    localparam logic [2:0] PH_ERASE_WAIT   = 3'd2;
    localparam logic [2:0] PH_PROGRAM      = 3'd3;
    localparam logic [2:0] PH_TOGGLE_FIRST = 3'd4;
    localparam logic [2:0] PH_TOGGLE_CHECK = 3'd5;

    // input commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PROG  = 2'd1;
    localparam logic [1:0] CMD_ERASE = 2'd2;

    // result ops
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_UNIT   = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // burst kinds handed from front to back
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_PROG   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ADDR_A   = 2'd0;
    localparam logic [1:0] CFG_ADDR_B   = 2'd1;
    localparam logic [1:0] CFG_UNIT     = 2'd2;
    localparam logic [1:0] CFG_RETRY_ON = 2'd3;

    localparam logic [15:0] ADDR_A_RST = 16'h5555;
    localparam logic [15:0] ADDR_B_RST = 16'h2AAA;
    localparam logic [8:0]  UNIT_RST   = 9'd1;

    // flash command bytes
    localparam logic [7:0] CB_UNLOCK1 = 8'hAA;
    localparam logic [7:0] CB_UNLOCK2 = 8'h55;
    localparam logic [7:0] CB_PROGRAM = 8'hA0;
    localparam logic [7:0] CB_ERASE   = 8'h80;
    localparam logic [7:0] CB_SECTOR  = 8'h10;
    localparam logic [7:0] BYTE_ERASED = 8'hFF;
    localparam int         DQ6_BIT    = 6;

    localparam logic [2:0] ERASE_LAST_STEP = 3'd5;
    localparam logic [2:0] PROG_LAST_STEP  = 3'd3;

    typedef struct packed {
        logic [15:0] addr_a;
        logic [15:0] addr_b;
        logic [8:0]  unit_bytes;
        logic        retry_on;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] offset;
        logic [8:0]  unit;
        logic [2:0]  phase;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: rtl/core/fpes_if.sv
// Stream interfaces of the flash program/erase sequencer: input items and results.
// No dependencies.
`timescale 1ns / 1ps

interface fpes_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [7:0]  poll_byte;
    logic        verify_mismatch;
    logic [7:0]  source_byte;

    modport source (output valid, command, start_address, byte_count, poll_byte,
                    verify_mismatch, source_byte, input ready);
    modport sink (input valid, command, start_address, byte_count, poll_byte,
                  verify_mismatch, source_byte, output ready);
endinterface

interface fpes_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [8:0]  unit_count;
    logic [15:0] buffer_offset;
    logic [2:0]  phase;
    logic        last;

    modport source (output valid, op, bus_address, bus_data, unit_count, buffer_offset,
                    phase, last, input ready);
    modport sink (input valid, op, bus_address, bus_data, unit_count, buffer_offset,
                  phase, last, output ready);
endinterface

// File: rtl/core/flash_program_erase_sequencer.sv
// NOR flash program/erase sequencer using JEDEC unlock cycles and DQ6 toggle
// polling. Every input item is taken while the descriptor queue (FIFO_DEPTH
// entries) has room; it yields one burst of results: one status result, six
// erase command writes, or two unlock writes, the program command and a unit write.
// The back end issues one result per cycle while out_ch.ready is high; start
// items replace a running job at once. Configuration writes take effect on
// the next clock and must only be made while no results are pending.
// Depends on fpes_pkg, fpes_if, fpes_fifo, fpes_front, fpes_back and the macros header.
`timescale 1ns / 1ps
`include "flash_program_erase_sequencer_macros.svh"

module flash_program_erase_sequencer #(
    parameter int MAX_UNIT    = fpes_pkg::MAX_UNIT_DEF,
    parameter int RETRY_LIMIT = fpes_pkg::RETRY_LIMIT_DEF,
    parameter int FIFO_DEPTH  = fpes_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fpes_in_if.sink     in_ch,
    fpes_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fpes_pkg::cfg_t       cfg_reg;
    fpes_pkg::desc_t      push_desc;
    fpes_pkg::desc_t      pop_desc;
    fpes_pkg::fifo_stat_t fifo_stat;
    logic                 push;
    logic                 pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.addr_a     <= fpes_pkg::ADDR_A_RST;
            cfg_reg.addr_b     <= fpes_pkg::ADDR_B_RST;
            cfg_reg.unit_bytes <= fpes_pkg::UNIT_RST;
            cfg_reg.retry_on   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpes_pkg::CFG_ADDR_A:   cfg_reg.addr_a     <= cfg_data;
                fpes_pkg::CFG_ADDR_B:   cfg_reg.addr_b     <= cfg_data;
                fpes_pkg::CFG_UNIT:     cfg_reg.unit_bytes <= cfg_data[8:0];
                fpes_pkg::CFG_RETRY_ON: cfg_reg.retry_on   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    fpes_front #(
        .MAX_UNIT    (MAX_UNIT),
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .fifo_full (fifo_stat.full),
        .push      (push),
        .push_desc (push_desc)
    );

    fpes_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (pop),
        .pop_data  (pop_desc),
        .stat      (fifo_stat)
    );

    fpes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_stat.empty),
        .pop_desc   (pop_desc),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    // a status result is always the only result of its item
    `FPES_ASSERT_IMPLY(a_status_alone, out_ch.valid && out_ch.op == fpes_pkg::OP_STATUS, out_ch.last)
    // unit write closes a program burst and leaves the job in first toggle read
    `FPES_ASSERT_IMPLY(a_unit_last, out_ch.valid && out_ch.op == fpes_pkg::OP_UNIT, out_ch.last && out_ch.phase == fpes_pkg::PH_TOGGLE_FIRST)
    // the only burst closing on a byte write is the erase, with the sector command
    `FPES_ASSERT_IMPLY(a_erase_end, out_ch.valid && out_ch.op == fpes_pkg::OP_BYTE && out_ch.last, out_ch.bus_data == fpes_pkg::CB_SECTOR && out_ch.phase == fpes_pkg::PH_ERASE_WAIT)
    // queue never pops while it is empty
    `FPES_ASSERT_ALWAYS(a_pop_ok, !pop || !fifo_stat.empty)

endmodule

// File: rtl/core/fpes_fifo.sv
// Short descriptor queue between sequencer front and back.
// Depends on fpes_pkg.
`timescale 1ns / 1ps

module fpes_fifo #(
    parameter int DEPTH = fpes_pkg::FIFO_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fpes_pkg::desc_t     push_data,
    input  logic                pop,
    output fpes_pkg::desc_t     pop_data,
    output fpes_pkg::fifo_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    fpes_pkg::desc_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/fpes_front.sv
// Sequencer front: accepts items, steps the job state, queues one burst per item.
// Depends on fpes_pkg and fpes_in_if.
`timescale 1ns / 1ps

module fpes_front #(
    parameter int MAX_UNIT    = fpes_pkg::MAX_UNIT_DEF,
    parameter int RETRY_LIMIT = fpes_pkg::RETRY_LIMIT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    fpes_in_if.sink         in_ch,
    input  fpes_pkg::cfg_t  cfg,
    input  logic            fifo_full,
    output logic            push,
    output fpes_pkg::desc_t push_desc
);

    localparam logic [16:0] MAX_UNIT_W = 17'(MAX_UNIT);
    localparam logic [4:0]  RETRY_MAX  = 5'(RETRY_LIMIT);

    logic [2:0]  phase_reg,  phase_next;
    logic        erase_reg,  erase_next;
    logic [15:0] addr_reg,   addr_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] offset_reg, offset_next;
    logic        toggle_reg, toggle_next;
    logic [4:0]  retry_reg,  retry_next;

    logic [8:0]  eff_unit;
    logic [15:0] eff_unit_w;
    logic [1:0]  kind;
    logic        dq6;
    logic        is_start;

    assign in_ch.ready = !fifo_full;
    assign push        = in_ch.valid && !fifo_full;
    assign dq6         = in_ch.poll_byte[fpes_pkg::DQ6_BIT];
    assign is_start    = (in_ch.command == fpes_pkg::CMD_PROG)
                      || (in_ch.command == fpes_pkg::CMD_ERASE);

    // unit size clamped to 1..MAX_UNIT
    always_comb
    begin
        if (cfg.unit_bytes == '0)
        begin
            eff_unit = 9'd1;
        end
        else if ({8'd0, cfg.unit_bytes} > MAX_UNIT_W)
        begin
            eff_unit = MAX_UNIT_W[8:0];
        end
        else
        begin
            eff_unit = cfg.unit_bytes;
        end
    end

    assign eff_unit_w = {7'd0, eff_unit};

    always_comb
    begin
        phase_next  = phase_reg;
        erase_next  = erase_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        toggle_next = toggle_reg;
        retry_next  = retry_reg;
        kind        = fpes_pkg::KIND_STATUS;
        if (is_start)
        begin
            erase_next  = (in_ch.command == fpes_pkg::CMD_ERASE);
            phase_next  = erase_next ? fpes_pkg::PH_ERASE : fpes_pkg::PH_PROGRAM;
            addr_next   = in_ch.start_address;
            remain_next = erase_next ? eff_unit_w : in_ch.byte_count;
            offset_next = '0;
            retry_next  = '0;
        end
        else
        begin
            case (phase_reg)
                fpes_pkg::PH_ERASE:
                begin
                    kind       = fpes_pkg::KIND_ERASE;
                    phase_next = fpes_pkg::PH_ERASE_WAIT;
                end
                fpes_pkg::PH_ERASE_WAIT:
                begin
                    if (in_ch.poll_byte == fpes_pkg::BYTE_ERASED)
                    begin
                        phase_next = fpes_pkg::PH_IDLE;
                    end
                end
                fpes_pkg::PH_PROGRAM:
                begin
                    // a lone erased byte needs no write
                    if (eff_unit != 9'd1 || in_ch.source_byte != fpes_pkg::BYTE_ERASED)
                    begin
                        kind = fpes_pkg::KIND_PROG;
                    end
                    phase_next = fpes_pkg::PH_TOGGLE_FIRST;
                end
                fpes_pkg::PH_TOGGLE_FIRST:
                begin
                    toggle_next = dq6;
                    phase_next  = fpes_pkg::PH_TOGGLE_CHECK;
                end
                fpes_pkg::PH_TOGGLE_CHECK:
                begin
                    if (dq6 == toggle_reg && cfg.retry_on && !erase_reg
                        && retry_reg < RETRY_MAX && in_ch.verify_mismatch)
                    begin
                        // reprogram; toggle bit keeps its old value
                        retry_next = retry_reg + 1'b1;
                        phase_next = fpes_pkg::PH_PROGRAM;
                    end
                    else
                    begin
                        toggle_next = dq6;
                        if (dq6 == toggle_reg)
                        begin
                            retry_next  = '0;
                            addr_next   = addr_reg + eff_unit_w;
                            offset_next = offset_reg + eff_unit_w;
                            remain_next = (remain_reg > eff_unit_w) ?
                                          remain_reg - eff_unit_w : '0;
                            phase_next  = (remain_next == '0 || erase_reg) ?
                                          fpes_pkg::PH_IDLE : fpes_pkg::PH_PROGRAM;
                        end
                    end
                end
                default:
                begin
                    phase_next = fpes_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        push_desc.kind    = kind;
        push_desc.address = addr_next;
        push_desc.offset  = offset_reg;
        push_desc.unit    = eff_unit;
        push_desc.phase   = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fpes_pkg::PH_IDLE;
            erase_reg  <= 1'b0;
            addr_reg   <= '0;
            remain_reg <= '0;
            offset_reg <= '0;
            toggle_reg <= 1'b0;
            retry_reg  <= '0;
        end
        else if (push)
        begin
            phase_reg  <= phase_next;
            erase_reg  <= erase_next;
            addr_reg   <= addr_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
            toggle_reg <= toggle_next;
            retry_reg  <= retry_next;
        end
    end

endmodule

// File: rtl/core/fpes_back.sv
// Sequencer back: expands queued bursts into bus write and status results, one per cycle while out_ch.ready is high.
// Depends on fpes_pkg and fpes_out_if.
`timescale 1ns / 1ps

module fpes_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fpes_pkg::cfg_t  cfg,
    input  logic            fifo_empty,
    input  fpes_pkg::desc_t pop_desc,
    output logic            pop,
    fpes_out_if.source      out_ch
);

    fpes_pkg::desc_t desc_reg;
    logic            busy_reg;
    logic [2:0]      step_reg;
    logic            last_step;
    logic            xfer;
    logic            load;

    always_comb
    begin
        case (desc_reg.kind)
            fpes_pkg::KIND_ERASE: last_step = (step_reg == fpes_pkg::ERASE_LAST_STEP);
            fpes_pkg::KIND_PROG:  last_step = (step_reg == fpes_pkg::PROG_LAST_STEP);
            default:              last_step = 1'b1;
        endcase
    end

    assign xfer = out_ch.valid && out_ch.ready;
    assign load = !busy_reg || (xfer && last_step);
    assign pop  = load && !fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b0;
        end
        else if (xfer)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= pop_desc;
        end
    end

    always_comb
    begin
        out_ch.valid         = busy_reg;
        out_ch.last          = last_step;
        out_ch.phase         = desc_reg.phase;
        out_ch.op            = fpes_pkg::OP_BYTE;
        out_ch.bus_address   = cfg.addr_a;
        out_ch.bus_data      = '0;
        out_ch.unit_count    = '0;
        out_ch.buffer_offset = '0;
        case (desc_reg.kind)
            fpes_pkg::KIND_ERASE:
            begin
                case (step_reg)
                    3'd0: out_ch.bus_data = fpes_pkg::CB_UNLOCK1;
                    3'd1:
                    begin
                        out_ch.bus_address = cfg.addr_b;
                        out_ch.bus_data    = fpes_pkg::CB_UNLOCK2;
                    end
                    3'd2: out_ch.bus_data = fpes_pkg::CB_ERASE;
                    3'd3: out_ch.bus_data = fpes_pkg::CB_UNLOCK1;
                    3'd4:
                    begin
                        out_ch.bus_address = cfg.addr_b;
                        out_ch.bus_data    = fpes_pkg::CB_UNLOCK2;
                    end
                    default: out_ch.bus_data = fpes_pkg::CB_SECTOR;
                endcase
            end
            fpes_pkg::KIND_PROG:
            begin
                case (step_reg)
                    3'd0: out_ch.bus_data = fpes_pkg::CB_UNLOCK1;
                    3'd1:
                    begin
                        out_ch.bus_address = cfg.addr_b;
                        out_ch.bus_data    = fpes_pkg::CB_UNLOCK2;
                    end
                    3'd2: out_ch.bus_data = fpes_pkg::CB_PROGRAM;
                    default:
                    begin
                        out_ch.op            = fpes_pkg::OP_UNIT;
                        out_ch.bus_address   = desc_reg.address;
                        out_ch.unit_count    = desc_reg.unit;
                        out_ch.buffer_offset = desc_reg.offset;
                    end
                endcase
            end
            default:
            begin
                out_ch.op          = fpes_pkg::OP_STATUS;
                out_ch.bus_address = desc_reg.address;
            end
        endcase
    end

endmodule
